/* sv/brfr_pkg.sv */
// Shared types, constants and codes of the brace frame receiver ring.
package brfr_pkg;

    localparam int RING_BUFFERS = 4;
    localparam int FRAME_BYTES  = 64;

    localparam int PTR_W    = (RING_BUFFERS > 1) ? $clog2(RING_BUFFERS) : 1;
    localparam int POS_W    = $clog2(FRAME_BYTES);
    localparam int CNT_W    = $clog2(FRAME_BYTES + 1);
    localparam int MEM_AW   = PTR_W + POS_W;
    localparam int RELOAD_W = 24;
    localparam int CMP_W    = 9;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 24'd100000;
    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int APB_AW    = 3;

    localparam logic REG_TIMEOUT_RELOAD = 1'b0;

    typedef enum logic [2:0] {
        OP_BYTE    = 3'd0,
        OP_TICK    = 3'd1,
        OP_FETCH   = 3'd2,
        OP_READ    = 3'd3,
        OP_RELEASE = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_RING_FULL = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_EXTRA_REL = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_NO_FRAME  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        BUF_EMPTY      = 2'd0,
        BUF_RECEIVING  = 2'd1,
        BUF_FULL       = 2'd2,
        BUF_IN_PROCESS = 2'd3
    } buf_state_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(RING_BUFFERS - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

endpackage

/* sv/brfr_ctrl.sv */
// Controller state machine that sequences word intake and result commit.
module brfr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  brfr_pkg::stat_t stat,
    output brfr_pkg::cmd_t  cmd
);

    brfr_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brfr_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            brfr_pkg::CS_IDLE: begin
                if (s_tvalid) begin
                    state_next = brfr_pkg::CS_EXEC;
                end
            end
            brfr_pkg::CS_EXEC: begin
                if (stat.out_free) begin
                    state_next = brfr_pkg::CS_IDLE;
                end
            end
            default: state_next = brfr_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            brfr_pkg::CS_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            brfr_pkg::CS_EXEC: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/brfr_dp.sv */
// Datapath with frame store, per-buffer state, ring pointers and output register.
module brfr_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  brfr_pkg::cmd_t                  cmd,
    output brfr_pkg::stat_t                 stat,
    input  logic [2:0]                     s_opcode,
    input  logic [7:0]                     s_rx_byte,
    input  logic [5:0]                     s_byte_pos,
    input  logic [brfr_pkg::RELOAD_W-1:0]  timeout_reload,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [brfr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int RB = brfr_pkg::RING_BUFFERS;

    logic [7:0] frame_mem [2**brfr_pkg::MEM_AW];
    logic [7:0] rd_data_reg;

    brfr_pkg::buf_state_t              bstate_reg [RB];
    logic [brfr_pkg::CNT_W-1:0]        bcount_reg [RB];
    logic [brfr_pkg::RELOAD_W-1:0]     cdown_reg  [RB];
    logic [brfr_pkg::PTR_W-1:0]        wptr_reg, wptr_next;
    logic [brfr_pkg::PTR_W-1:0]        rptr_reg, rptr_next;

    logic [2:0]                        op_reg;
    logic [7:0]                        ch_reg;
    logic [5:0]                        pos_reg;

    logic                              m_tvalid_reg;
    logic [brfr_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [brfr_pkg::PTR_W-1:0]        sel;
    brfr_pkg::buf_state_t              st_cur, st_next;
    logic [brfr_pkg::CNT_W-1:0]        cnt_cur, cnt_next, cnt_base;
    logic [brfr_pkg::RELOAD_W-1:0]     cd_cur, cd_next;
    logic                              mem_we;
    logic [brfr_pkg::MEM_AW-1:0]       mem_waddr;
    logic [brfr_pkg::PTR_W-1:0]        nxt_ptr;
    logic [2:0]                        status;
    logic                              ready;
    logic [6:0]                        length;
    logic [7:0]                        data;

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_opcode;
            ch_reg      <= s_rx_byte;
            pos_reg     <= s_byte_pos;
            rd_data_reg <= frame_mem[{rptr_reg, brfr_pkg::POS_W'(s_byte_pos)}];
        end
        if (mem_we) begin
            frame_mem[mem_waddr] <= ch_reg;
        end
    end

    always_comb begin
        if (op_reg == brfr_pkg::OP_BYTE || op_reg == brfr_pkg::OP_TICK) begin
            sel = wptr_reg;
        end else begin
            sel = rptr_reg;
        end
        st_cur  = bstate_reg[sel];
        cnt_cur = bcount_reg[sel];
        cd_cur  = cdown_reg[sel];
        nxt_ptr = brfr_pkg::ring_next(sel);
    end

    always_comb begin
        st_next   = st_cur;
        cnt_next  = cnt_cur;
        cd_next   = cd_cur;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        mem_we    = 1'b0;
        mem_waddr = {sel, brfr_pkg::POS_W'(0)};
        cnt_base  = cnt_cur;
        status    = brfr_pkg::ST_OK;
        ready     = 1'b0;
        length    = '0;
        data      = '0;
        unique case (op_reg)
            brfr_pkg::OP_BYTE: begin
                cd_next = timeout_reload;
                unique case (st_cur)
                    brfr_pkg::BUF_EMPTY: begin
                        if (ch_reg == brfr_pkg::OPEN_BRACE) begin
                            mem_we   = 1'b1;
                            cnt_next = brfr_pkg::CNT_W'(1);
                            st_next  = brfr_pkg::BUF_RECEIVING;
                        end
                    end
                    brfr_pkg::BUF_IN_PROCESS: status = brfr_pkg::ST_BUSY;
                    brfr_pkg::BUF_FULL:       status = brfr_pkg::ST_RING_FULL;
                    default: begin
                        if (ch_reg == brfr_pkg::OPEN_BRACE) begin
                            cnt_base = '0;
                        end
                        cnt_next = cnt_base;
                        if (cnt_base >= brfr_pkg::CNT_W'(brfr_pkg::FRAME_BYTES)) begin
                            status = brfr_pkg::ST_OVERFLOW;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = {sel, brfr_pkg::POS_W'(cnt_base)};
                            cnt_next  = cnt_base + 1'b1;
                            if (ch_reg == brfr_pkg::CLOSE_BRACE) begin
                                st_next = brfr_pkg::BUF_FULL;
                                if (nxt_ptr == rptr_reg) begin
                                    status = brfr_pkg::ST_RING_FULL;
                                end else begin
                                    wptr_next = nxt_ptr;
                                end
                            end
                        end
                    end
                endcase
            end
            brfr_pkg::OP_TICK: begin
                if (st_cur == brfr_pkg::BUF_RECEIVING) begin
                    if (cd_cur == '0) begin
                        st_next  = brfr_pkg::BUF_EMPTY;
                        cnt_next = '0;
                        cd_next  = timeout_reload;
                        status   = brfr_pkg::ST_TIMEOUT;
                    end else begin
                        cd_next = cd_cur - 1'b1;
                    end
                end
            end
            brfr_pkg::OP_FETCH: begin
                if (st_cur == brfr_pkg::BUF_FULL) begin
                    st_next = brfr_pkg::BUF_IN_PROCESS;
                    ready   = 1'b1;
                    length  = 7'(cnt_cur);
                end else begin
                    status = brfr_pkg::ST_NO_FRAME;
                end
            end
            brfr_pkg::OP_READ: begin
                length = 7'(cnt_cur);
                if (brfr_pkg::CMP_W'(pos_reg) < brfr_pkg::CMP_W'(cnt_cur)) begin
                    data = rd_data_reg;
                end
            end
            brfr_pkg::OP_RELEASE: begin
                st_next  = brfr_pkg::BUF_EMPTY;
                cnt_next = '0;
                cd_next  = timeout_reload;
                if (wptr_reg == rptr_reg) begin
                    status = brfr_pkg::ST_EXTRA_REL;
                end else begin
                    rptr_next = nxt_ptr;
                end
            end
            default: begin
                status = brfr_pkg::ST_OK;
            end
        endcase
        mem_we = mem_we && cmd.commit;
        m_tdata_next = {5'd0, data, length, ready, status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RB; i++) begin
                bstate_reg[i] <= brfr_pkg::BUF_EMPTY;
                bcount_reg[i] <= '0;
                cdown_reg[i]  <= brfr_pkg::RELOAD_RESET;
            end
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                bstate_reg[sel] <= st_next;
                bcount_reg[sel] <= cnt_next;
                cdown_reg[sel]  <= cd_next;
                wptr_reg        <= wptr_next;
                rptr_reg        <= rptr_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

/* sv/brace_frame_receiver_ring_unit.sv */
// Top level of the brace frame receiver ring with its configuration register.
//
// Words arrive on the s_ stream: s_tuser carries the opcode (received byte,
// idle tick, fetch head, read head byte, release head) and s_tdata the byte
// and the read position. Every accepted word yields exactly one result word
// on the m_ stream with status, frame_ready, frame_length and data_byte.
// Each word is first accepted, which latches it and reads the frame store,
// and then committed, which updates the per-buffer state and loads the
// output register. A new word is accepted only once the previous one is
// committed; m_tvalid rises when the commit loads the output register.
// The output register holds a result while m_tready is low; the next word
// is still accepted and waits in the datapath until the register frees up.
// The APB port holds timeout_reload at byte address 0; write it only while
// the block is idle. Synchronous reset empties all buffers, clears both
// ring pointers and counts, reloads the countdowns with the reset value of
// timeout_reload and drops any pending result. Frame contents are not
// cleared; only bytes inside a frame's count are ever returned.
module brace_frame_receiver_ring_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rx_byte [7:0], byte_pos [13:8], zero padding [15:14]
    input  logic [brfr_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode [2:0]
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [2:0], frame_ready [3], frame_length [10:4], data_byte [18:11]
    output logic [brfr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [brfr_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [brfr_pkg::RELOAD_W-1:0] reload_reg;
    brfr_pkg::cmd_t                cmd;
    brfr_pkg::stat_t               stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= brfr_pkg::RELOAD_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == brfr_pkg::REG_TIMEOUT_RELOAD) begin
            reload_reg <= pwdata[brfr_pkg::RELOAD_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == brfr_pkg::REG_TIMEOUT_RELOAD) begin
            prdata = 32'(reload_reg);
        end else begin
            prdata = '0;
        end
    end

    brfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brfr_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_tuser),
        .s_rx_byte      (s_tdata[7:0]),
        .s_byte_pos     (s_tdata[13:8]),
        .timeout_reload (reload_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule
